[hdl/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and helpers of the pulse/sawtooth sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // address decode
  localparam logic [15:0] ADDR_MASK      = 16'hF003;
  localparam logic [3:0]  BANK_P0_NIBBLE = 4'h9;
  localparam logic [3:0]  BANK_P1_NIBBLE = 4'hA;
  localparam logic [3:0]  BANK_SW_NIBBLE = 4'hB;

  // register offsets inside a bank
  localparam logic [1:0] OFF_CTRL   = 2'd0;
  localparam logic [1:0] OFF_PER_LO = 2'd1;
  localparam logic [1:0] OFF_PER_HI = 2'd2;
  localparam logic [1:0] OFF_UNUSED = 2'd3;

  // register fields
  localparam int unsigned ENABLE_BIT = 7;
  localparam int unsigned MODE_BIT   = 7;
  localparam logic [5:0]  SAW_RATE_MASK = 6'h3F;
  localparam logic [2:0]  SAW_LAST_STEP = 3'd7;

  localparam int unsigned NUM_PULSE = 2;
  localparam int unsigned SAMPLE_W  = 14;
  localparam int unsigned LEVEL_W   = 13;
  localparam int unsigned PCNT_W    = 13;
  localparam int unsigned SCNT_W    = 14;
  localparam int unsigned ACCUM_W   = 9;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 14'd11712;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_WRITE,
    OP_TICK
  } op_e;

  typedef enum logic [1:0] {
    BANK_PULSE0,
    BANK_PULSE1,
    BANK_SAW
  } bank_e;

  typedef struct packed {
    op_e        op;
    bank_e      bank;
    logic [1:0] off;
    logic [7:0] data;
  } cmd_t;

  // v * 256 * 6 / 8 == v * 192
  function automatic logic [LEVEL_W-1:0] scale_level(input logic [4:0] v);
    scale_level = {1'b0, v, 7'b0} + {2'b0, v, 6'b0};
  endfunction

endpackage

[hdl/psg_if.sv]
// ----------------------------------------------------------------------------
// psg_if
// Valid/ready channels: input items, classified commands and samples.
// ----------------------------------------------------------------------------
interface psg_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output kind, output address, output write_data,
                  input ready);
  modport sink   (input valid, input kind, input address, input write_data,
                  output ready);
endinterface

interface psg_cmd_if;
  logic          valid;
  logic          ready;
  psg_pkg::cmd_t cmd;

  modport source (output valid, output cmd, input ready);
  modport sink   (input valid, input cmd, output ready);
endinterface

interface psg_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hdl/psg_front.sv]
// ----------------------------------------------------------------------------
// psg_front
// Accepts input beats, decodes write addresses and forwards ticks and mapped
// writes as commands. Unmapped writes are dropped here.
// ----------------------------------------------------------------------------
module psg_front (
  psg_in_if.sink     in_i,
  psg_cmd_if.source  cmd_o
);
  import psg_pkg::*;

  logic [15:0] masked;
  logic        mapped;
  bank_e       bank;

  assign masked = in_i.address & ADDR_MASK;

  always_comb begin
    mapped = (masked[1:0] != OFF_UNUSED);
    bank   = BANK_PULSE0;
    unique case (masked[15:12])
      BANK_P0_NIBBLE: bank = BANK_PULSE0;
      BANK_P1_NIBBLE: bank = BANK_PULSE1;
      BANK_SW_NIBBLE: bank = BANK_SAW;
      default:        mapped = 1'b0;
    endcase
  end

  assign in_i.ready     = cmd_o.ready;
  assign cmd_o.valid    = in_i.valid && ((in_i.kind == KIND_TICK) || mapped);
  assign cmd_o.cmd.op   = (in_i.kind == KIND_TICK) ? OP_TICK : OP_WRITE;
  assign cmd_o.cmd.bank = bank;
  assign cmd_o.cmd.off  = masked[1:0];
  assign cmd_o.cmd.data = in_i.write_data;

endmodule

[hdl/psg_queue.sv]
// ----------------------------------------------------------------------------
// psg_queue
// Short command FIFO between the decode front and the channel back end.
// ----------------------------------------------------------------------------
module psg_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  psg_cmd_if.sink    push_i,
  psg_cmd_if.source  pop_o
);
  import psg_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_i.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.cmd    = mem_q[rd_ptr_q];

  assign push = push_i.valid && push_i.ready;
  assign pop  = pop_o.valid && pop_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");
`endif

endmodule

[hdl/psg_back.sv]
// ----------------------------------------------------------------------------
// psg_back
// Channel registers, pulse and sawtooth counters, sample mixer and the
// output register.
// ----------------------------------------------------------------------------
module psg_back (
  input  logic       clk_i,
  input  logic       rst_ni,
  psg_cmd_if.sink    cmd_i,
  psg_out_if.source  out_o
);
  import psg_pkg::*;

  // pulse channel state
  logic [7:0]        p_ctrl_q [NUM_PULSE];
  logic [7:0]        p_ctrl_d [NUM_PULSE];
  logic [7:0]        p_lo_q   [NUM_PULSE];
  logic [7:0]        p_lo_d   [NUM_PULSE];
  logic [7:0]        p_hi_q   [NUM_PULSE];
  logic [7:0]        p_hi_d   [NUM_PULSE];
  logic [PCNT_W-1:0] p_cnt_q  [NUM_PULSE];
  logic [PCNT_W-1:0] p_cnt_d  [NUM_PULSE];
  logic [3:0]        p_step_q [NUM_PULSE];
  logic [3:0]        p_step_d [NUM_PULSE];
  logic [LEVEL_W-1:0] p_level [NUM_PULSE];

  // sawtooth state
  logic [7:0]         s_rate_q, s_rate_d;
  logic [7:0]         s_lo_q, s_lo_d;
  logic [7:0]         s_hi_q, s_hi_d;
  logic [SCNT_W-1:0]  s_cnt_q, s_cnt_d;
  logic [2:0]         s_step_q, s_step_d;
  logic [ACCUM_W-1:0] s_accum_q, s_accum_d;
  logic [LEVEL_W-1:0] s_level;
  logic [2:0]         s_step_inc;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;

  logic fire, tick, wr, psel;

  // a tick needs room in the output register, a write never waits
  assign cmd_i.ready = (cmd_i.cmd.op == OP_WRITE) || !out_valid_q || out_o.ready;
  assign fire = cmd_i.valid && cmd_i.ready;
  assign tick = fire && (cmd_i.cmd.op == OP_TICK);
  assign wr   = fire && (cmd_i.cmd.op == OP_WRITE);
  assign psel = (cmd_i.cmd.bank == BANK_PULSE1);

  assign s_step_inc = s_step_q + 1'b1;

  always_comb begin
    for (int p = 0; p < NUM_PULSE; p++) begin
      p_ctrl_d[p] = p_ctrl_q[p];
      p_lo_d[p]   = p_lo_q[p];
      p_hi_d[p]   = p_hi_q[p];
      p_cnt_d[p]  = p_cnt_q[p];
      p_step_d[p] = p_step_q[p];
      p_level[p]  = '0;
      if (p_hi_q[p][ENABLE_BIT]) begin
        if (p_ctrl_q[p][MODE_BIT] || (p_step_q[p] > {1'b0, p_ctrl_q[p][6:4]})) begin
          p_level[p] = scale_level({1'b0, p_ctrl_q[p][3:0]});
        end
        if (tick && !p_ctrl_q[p][MODE_BIT]) begin
          if (p_cnt_q[p] <= PCNT_W'(1)) begin
            p_cnt_d[p]  = {1'b0, p_hi_q[p][3:0], p_lo_q[p]} + 1'b1;
            p_step_d[p] = p_step_q[p] + 1'b1;
          end else begin
            p_cnt_d[p] = p_cnt_q[p] - 1'b1;
          end
        end
      end
    end

    s_rate_d  = s_rate_q;
    s_lo_d    = s_lo_q;
    s_hi_d    = s_hi_q;
    s_cnt_d   = s_cnt_q;
    s_step_d  = s_step_q;
    s_accum_d = s_accum_q;
    s_level   = '0;
    if (s_hi_q[ENABLE_BIT]) begin
      s_level = scale_level(s_accum_q[7:3]);
      if (tick) begin
        if (s_cnt_q <= SCNT_W'(1)) begin
          s_cnt_d = {({1'b0, s_hi_q[3:0], s_lo_q} + 1'b1), 1'b0};
          if (s_step_inc == SAW_LAST_STEP) begin
            s_step_d  = '0;
            s_accum_d = '0;
          end else begin
            s_step_d  = s_step_inc;
            s_accum_d = s_accum_q + {3'b0, s_rate_q[5:0] & SAW_RATE_MASK};
          end
        end else begin
          s_cnt_d = s_cnt_q - 1'b1;
        end
      end
    end

    if (wr) begin
      unique case (cmd_i.cmd.bank)
        BANK_PULSE0, BANK_PULSE1: begin
          unique case (cmd_i.cmd.off)
            OFF_CTRL:   p_ctrl_d[psel] = cmd_i.cmd.data;
            OFF_PER_LO: p_lo_d[psel]   = cmd_i.cmd.data;
            OFF_PER_HI: p_hi_d[psel]   = cmd_i.cmd.data;
            default: ;
          endcase
        end
        BANK_SAW: begin
          unique case (cmd_i.cmd.off)
            OFF_CTRL:   s_rate_d = cmd_i.cmd.data;
            OFF_PER_LO: s_lo_d   = cmd_i.cmd.data;
            OFF_PER_HI: s_hi_d   = cmd_i.cmd.data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    out_valid_d = out_valid_q;
    sample_d    = sample_q;
    if (tick) begin
      out_valid_d = 1'b1;
      sample_d    = {1'b0, p_level[0]} + {1'b0, p_level[1]} + {1'b0, s_level};
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PULSE; p++) begin
        p_ctrl_q[p] <= '0;
        p_lo_q[p]   <= '0;
        p_hi_q[p]   <= '0;
        p_cnt_q[p]  <= '0;
        p_step_q[p] <= '0;
      end
      s_rate_q    <= '0;
      s_lo_q      <= '0;
      s_hi_q      <= '0;
      s_cnt_q     <= '0;
      s_step_q    <= '0;
      s_accum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int p = 0; p < NUM_PULSE; p++) begin
        p_ctrl_q[p] <= p_ctrl_d[p];
        p_lo_q[p]   <= p_lo_d[p];
        p_hi_q[p]   <= p_hi_d[p];
        p_cnt_q[p]  <= p_cnt_d[p];
        p_step_q[p] <= p_step_d[p];
      end
      s_rate_q    <= s_rate_d;
      s_lo_q      <= s_lo_d;
      s_hi_q      <= s_hi_d;
      s_cnt_q     <= s_cnt_d;
      s_step_q    <= s_step_d;
      s_accum_q   <= s_accum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

`ifndef SYNTHESIS
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sample_q <= SAMPLE_MAX))
    else $error("sample above full scale");

  a_saw_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_step_q != SAW_LAST_STEP)
    else $error("saw step reached its clear value");

  a_write_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !out_valid_q) |=> !out_valid_q)
    else $error("register write produced a sample beat");
`endif

endmodule

[hdl/pulse_saw_sound_generator.sv]
// Path: an accepted beat is stored in the command queue; a tick taken from
//   it loads the output register, which drives out_o. Throughput: one input
//   beat per cycle while the queue has room; the back end retires one command
//   per cycle and a tick only waits when that register is full and stalled.
// Reset: all channel registers, counters, step and accumulator go to zero,
//   the queue empties and no sample is pending; no clearing pass is needed.
// ----------------------------------------------------------------------------
// pulse_saw_sound_generator
// Two pulse channels and one sawtooth channel; register writes and clock
// ticks in, one mixed sample out per tick.
// ----------------------------------------------------------------------------
module pulse_saw_sound_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  psg_in_if.sink     in_i,
  psg_out_if.source  out_o
);
  import psg_pkg::*;

  psg_cmd_if front_cmd ();
  psg_cmd_if back_cmd ();

  psg_front u_front (
    .in_i  (in_i),
    .cmd_o (front_cmd)
  );

  psg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_cmd),
    .pop_o  (back_cmd)
  );

  psg_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (back_cmd),
    .out_o  (out_o)
  );

endmodule
